[rtl/core/rwc_pkg.sv]
// Shared types and constants for the wall rectangle collision block.
`timescale 1ns / 1ps
`default_nettype none

package rwc_pkg;

    localparam int COORD_W = 24;           // signed 16.8 edge coordinate
    localparam int SIZE_W  = COORD_W - 1;  // unsigned 15.8 size
    localparam int EDGE_W  = COORD_W + 1;  // edge plus size, never overflows
    localparam int SLOT_W  = 6;
    localparam int CFG_W   = 7;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] rect_left;
        logic signed [COORD_W-1:0] rect_top;
        logic [SIZE_W-1:0]         rect_width;
        logic [SIZE_W-1:0]         rect_height;
    } in_item_t;

    typedef struct packed {
        logic collided;
        logic right_hit;
        logic left_hit;
        logic top_hit;
    } out_item_t;

    // A rectangle held by its left, top, right and bottom edges, right and bottom already summed.
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [EDGE_W-1:0]  right;
        logic signed [EDGE_W-1:0]  bottom;
    } wall_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } rwc_state_t;

endpackage : rwc_pkg

`default_nettype wire

[rtl/core/rwc_test.sv]
// Edge comparison unit: tests the query rectangle against one stored wall.
`timescale 1ns / 1ps
`default_nettype none

module rwc_test import rwc_pkg::*; (
    input  wire wall_t     query,
    input  wire wall_t     wall,
    output out_item_t      flags
);

    logic signed [EDGE_W-1:0] ql;
    logic signed [EDGE_W-1:0] qt;
    logic signed [EDGE_W-1:0] wl;
    logic signed [EDGE_W-1:0] wt;
    logic                     overlap;

    // Left and top are widened so that every comparison is on one width.
    assign ql = $signed({query.left[COORD_W-1], query.left});
    assign qt = $signed({query.top[COORD_W-1], query.top});
    assign wl = $signed({wall.left[COORD_W-1], wall.left});
    assign wt = $signed({wall.top[COORD_W-1], wall.top});

    // The larger left lies below the smaller right on both axes.
    assign overlap = (ql < query.right) && (ql < wall.right) &&
                     (wl < query.right) && (wl < wall.right) &&
                     (qt < query.bottom) && (qt < wall.bottom) &&
                     (wt < query.bottom) && (wt < wall.bottom);

    assign flags.collided  = overlap;
    assign flags.right_hit = overlap && (ql < wl) && (query.right > wl);
    assign flags.left_hit  = overlap && (ql > wl) && (ql < wall.right);
    assign flags.top_hit   = overlap && (qt < wall.bottom) && (query.bottom > wt) &&
                             (query.bottom >= wall.bottom);

endmodule : rwc_test

`default_nettype wire

[rtl/core/rect_wall_collision_sides.sv]
// Top level of the wall rectangle collision block: wall table, scan sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Payload
// --------  ---------  ----------------  ------------------------------------------
// cfg       in         cfg_wr_en         cfg_wr_data: walls_in_use
// s_        in         s_valid/s_ready   in_item_t: write or query rectangle
// m_        out        m_valid/m_ready   out_item_t: collided and the edge flags right/left/top_hit
//
// A write item gives no result; the block is ready again at once.
// A query item is accepted, then the scan reads one wall a cycle from the single
// table read port, the last wall is compared in the drain state, and the result is
// held in the done state, with walls_in_use capped at MAX_WALLS. With a count of zero
// the scan and the compare are skipped.
// Reset clears the sequencer and the count register only; the wall table has no clearing pass
// and holds nothing defined until a slot is written.
// A result held back by m_ready keeps the block busy, and no new item is accepted.

module rect_wall_collision_sides import rwc_pkg::*; #(
    parameter int MAX_WALLS = 64
) (
    input  wire             aclk,
    input  wire             aresetn,

    input  wire             cfg_wr_en,
    input  wire [CFG_W-1:0] cfg_wr_data,

    input  wire             s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,

    output logic            m_valid,
    input  wire             m_ready,
    output out_item_t       m_data
);

    localparam int IDX_W = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CNT_W = $clog2(MAX_WALLS + 1);

    rwc_state_t       state_reg, state_next;
    logic [CFG_W-1:0] walls_in_use_reg;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] issued_reg, issued_next;
    logic             rd_vld_reg, rd_vld_next;
    wall_t            query_reg, query_next;
    out_item_t        acc_reg, acc_next;
    wall_t            rd_wall_reg;

    wall_t            in_wall;
    wall_t            wall_mem [MAX_WALLS];
    logic             mem_we;
    logic             slot_ok;
    logic [CNT_W-1:0] n_sat;
    out_item_t        flags;

    // The incoming rectangle is turned into edges once, both for a write and for a query.
    assign in_wall.left   = s_data.rect_left;
    assign in_wall.top    = s_data.rect_top;
    assign in_wall.right  = $signed({s_data.rect_left[COORD_W-1], s_data.rect_left}) +
                            $signed({2'b00, s_data.rect_width});
    assign in_wall.bottom = $signed({s_data.rect_top[COORD_W-1], s_data.rect_top}) +
                            $signed({2'b00, s_data.rect_height});

    // Writes beyond the table are dropped; a count beyond the table is capped.
    assign slot_ok = int'(s_data.slot) < MAX_WALLS;
    assign n_sat   = (int'(walls_in_use_reg) > MAX_WALLS) ? CNT_W'(MAX_WALLS)
                                                          : CNT_W'(walls_in_use_reg);

    // Wall table: one write port for write items, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wall_mem[IDX_W'(s_data.slot)] <= in_wall;
        end
        rd_wall_reg <= wall_mem[issued_reg[IDX_W-1:0]];
    end

    rwc_test u_test (
        .query (query_reg),
        .wall  (rd_wall_reg),
        .flags (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walls_in_use_reg <= '0;
        end else if (cfg_wr_en) begin
            walls_in_use_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            n_reg      <= '0;
            issued_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            issued_reg <= issued_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        query_reg <= query_next;
        acc_reg   <= acc_next;
    end

    // Sequencer: the scan issues one table read a cycle, and the compare of each wall
    // follows in the cycle after its read, so the last wall is folded in during the drain.
    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        issued_next = issued_reg;
        rd_vld_next = 1'b0;
        query_next  = query_reg;
        acc_next    = acc_reg;
        mem_we      = 1'b0;

        if (rd_vld_reg) begin
            acc_next.collided  = acc_reg.collided  | flags.collided;
            acc_next.right_hit = acc_reg.right_hit | flags.right_hit;
            acc_next.left_hit  = acc_reg.left_hit  | flags.left_hit;
            acc_next.top_hit   = acc_reg.top_hit   | flags.top_hit;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.mode == MODE_QUERY) begin
                        query_next  = in_wall;
                        n_next      = n_sat;
                        issued_next = '0;
                        acc_next    = '0;
                        state_next  = (n_sat == '0) ? ST_DONE : ST_SCAN;
                    end else begin
                        mem_we = slot_ok;
                    end
                end
            end
            ST_SCAN: begin
                rd_vld_next = 1'b1;
                issued_next = issued_reg + CNT_W'(1);
                if (issued_next == n_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);
    assign m_data  = acc_reg;

    // The block works on one item at a time, so it never takes input with a result pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input accepted while a result is pending");

    // An edge flag can only come from an overlapping wall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.collided ||
                     !(m_data.right_hit || m_data.left_hit || m_data.top_hit)))
        else $error("edge flag set without a collision");

    // A query against an empty table answers at once with no collision.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_QUERY && walls_in_use_reg == '0)
        |=> (m_valid && !m_data.collided))
        else $error("empty-table query did not answer clear");

    // A write item leaves the block ready for the next item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_WRITE) |=> s_ready)
        else $error("write item stalled the block");

    // The scan never reads past the walls in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issued_reg < n_reg))
        else $error("scan ran past the walls in use");

endmodule : rect_wall_collision_sides

`default_nettype wire

[verif/rect_wall_collision_sides_tb.sv]
// Self-checking testbench for the wall rectangle collision block.
`timescale 1ns / 1ps

module rect_wall_collision_sides_tb;
    import rwc_pkg::*;

    // The table depth of the block as built here. Every slot is written before any
    // query scans it, since the table holds nothing defined after reset.
    localparam int MAX_WALLS = 64;

    // Extremes of the signed 16.8 coordinates and the unsigned 15.8 sizes.
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic [SIZE_W-1:0]         SIZE_MAX  = 23'h7FFFFF;

    // Cycles allowed for the block to settle once nothing more is expected. A
    // write item gives no result and leaves the block ready again at once; a full
    // scan plus a margin covers every case.
    localparam int SETTLE_CYCLES = MAX_WALLS + 8;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;

    rect_wall_collision_sides #(
        .MAX_WALLS (MAX_WALLS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // The testbench's own copy of the wall table and of the scan count register.
    logic signed [COORD_W-1:0] tbl_left   [MAX_WALLS];
    logic signed [COORD_W-1:0] tbl_top    [MAX_WALLS];
    logic [SIZE_W-1:0]         tbl_width  [MAX_WALLS];
    logic [SIZE_W-1:0]         tbl_height [MAX_WALLS];
    logic [CFG_W-1:0]          scan_count;

    // Flags expected from the block, oldest first, one entry per accepted query.
    out_item_t pending_flags[$];

    // Percentages that decide how often the sender idles and the receiver stalls.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int error_count;
    int writes_sent;
    int queries_sent;
    int results_checked;
    int collided_seen;
    int right_seen;
    int left_seen;
    int top_seen;

    // A 2 ns clock.
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Strict overlap of two spans on one axis: the larger start lies below the
    // smaller end. Spans of zero length can therefore never overlap anything.
    function automatic bit span_overlap(logic signed [EDGE_W-1:0] a_lo,
                                        logic signed [EDGE_W-1:0] a_hi,
                                        logic signed [EDGE_W-1:0] b_lo,
                                        logic signed [EDGE_W-1:0] b_hi);
        logic signed [EDGE_W-1:0] lo;
        logic signed [EDGE_W-1:0] hi;
        lo = (a_lo > b_lo) ? a_lo : b_lo;
        hi = (a_hi < b_hi) ? a_hi : b_hi;
        return lo < hi;
    endfunction

    // Works out the four flags that a query should give against the walls in use.
    // All edges are held one bit wider than the coordinates, so a right or bottom
    // edge summed from an extreme coordinate and size never wraps.
    function automatic out_item_t collision_flags(in_item_t q);
        out_item_t                flags;
        int                       walls;
        logic [SLOT_W-1:0]        idx;
        logic signed [EDGE_W-1:0] ql, qt, qr, qb;
        logic signed [EDGE_W-1:0] wl, wt, wr, wb;
        flags = '0;
        // A count above the table depth scans the whole table and no further.
        walls = (int'(scan_count) > MAX_WALLS) ? MAX_WALLS : int'(scan_count);
        ql = EDGE_W'(q.rect_left);
        qt = EDGE_W'(q.rect_top);
        qr = ql + $signed({2'b00, q.rect_width});
        qb = qt + $signed({2'b00, q.rect_height});
        for (int i = 0; i < walls; i++) begin
            idx = SLOT_W'(i);
            wl = EDGE_W'(tbl_left[idx]);
            wt = EDGE_W'(tbl_top[idx]);
            wr = wl + $signed({2'b00, tbl_width[idx]});
            wb = wt + $signed({2'b00, tbl_height[idx]});
            if (span_overlap(ql, qr, wl, wr) && span_overlap(qt, qb, wt, wb)) begin
                flags.collided = 1'b1;
                // The wall's left edge falls inside the rectangle's span.
                if (ql < wl && qr > wl) flags.right_hit = 1'b1;
                // The rectangle's left edge falls inside the wall's span.
                if (ql > wl && ql < wr) flags.left_hit = 1'b1;
                // The rectangle reaches the wall's bottom from below.
                if (qt < wb && qb > wt && qb >= wb) flags.top_hit = 1'b1;
            end
        end
        return flags;
    endfunction

    // Brings the testbench's copy of the block up to date with one accepted item.
    task automatic apply_item(in_item_t it);
        if (it.mode == MODE_WRITE) begin
            tbl_left[it.slot]   = it.rect_left;
            tbl_top[it.slot]    = it.rect_top;
            tbl_width[it.slot]  = it.rect_width;
            tbl_height[it.slot] = it.rect_height;
            writes_sent++;
        end else begin
            pending_flags = {pending_flags, collision_flags(it)};
            queries_sent++;
        end
    endtask

    function automatic in_item_t make_item(logic                      mode,
                                           int                        slot,
                                           logic signed [COORD_W-1:0] left,
                                           logic signed [COORD_W-1:0] top,
                                           logic [SIZE_W-1:0]         width,
                                           logic [SIZE_W-1:0]         height);
        in_item_t it;
        it.mode        = mode;
        it.slot        = SLOT_W'(slot);
        it.rect_left   = left;
        it.rect_top    = top;
        it.rect_width  = width;
        it.rect_height = height;
        return it;
    endfunction

    // Most rectangles are drawn from a small cluster around the origin so that
    // they overlap walls often; the rest take fully random bits, which reaches the
    // extremes of every field.
    function automatic in_item_t random_rect();
        in_item_t it;
        it.mode = ($urandom_range(0, 99) < 35) ? MODE_WRITE : MODE_QUERY;
        it.slot = SLOT_W'($urandom_range(0, MAX_WALLS - 1));
        if ($urandom_range(0, 99) < 15) begin
            it.rect_left   = COORD_W'($urandom);
            it.rect_top    = COORD_W'($urandom);
            it.rect_width  = SIZE_W'($urandom);
            it.rect_height = SIZE_W'($urandom);
        end else begin
            it.rect_left   = COORD_W'($urandom_range(0, 4095)) - COORD_W'(2048);
            it.rect_top    = COORD_W'($urandom_range(0, 4095)) - COORD_W'(2048);
            it.rect_width  = SIZE_W'($urandom_range(0, 1536));
            it.rect_height = SIZE_W'($urandom_range(0, 1536));
        end
        return it;
    endfunction

    // Offers one item and returns at the edge where the block takes it. An idle
    // gap, if one is drawn, comes first, so valid stays high between back-to-back
    // items and is never lowered and raised again within one step.
    task automatic send_item(in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        apply_item(it);
    endtask

    // The sender holds back until every expected result has come in.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (pending_flags.size() > 0) @(posedge aclk);
    endtask

    // Brings the block to rest: nothing offered, nothing expected, and a settling
    // wait after the last result has been taken.
    task automatic quiesce();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the scan count register while the block is at rest.
    task automatic set_walls_in_use(int count);
        quiesce();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(count);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        scan_count = CFG_W'(count);
    endtask

    // Selects one of the four mixes of sender idling and receiver stalling.
    task automatic set_idling(int mix);
        case (mix % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // The receiver stalls at random; at a stall percentage of zero it is always ready.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Every result taken from the block is compared with the oldest expectation.
    // Values are sampled at the edge, before any update that the edge causes.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_flags.size() == 0) begin
                report_mismatch($sformatf("result %b arrived with none expected", m_data));
            end else begin
                want = pending_flags.pop_front();
                results_checked++;
                if (m_data.collided !== want.collided)
                    report_mismatch($sformatf("collided got %b expected %b",
                                              m_data.collided, want.collided));
                if (m_data.right_hit !== want.right_hit)
                    report_mismatch($sformatf("right_hit got %b expected %b",
                                              m_data.right_hit, want.right_hit));
                if (m_data.left_hit !== want.left_hit)
                    report_mismatch($sformatf("left_hit got %b expected %b",
                                              m_data.left_hit, want.left_hit));
                if (m_data.top_hit !== want.top_hit)
                    report_mismatch($sformatf("top_hit got %b expected %b",
                                              m_data.top_hit, want.top_hit));
                collided_seen += want.collided;
                right_seen    += want.right_hit;
                left_seen     += want.left_hit;
                top_seen      += want.top_hit;
            end
        end
    end

    // After reset the count is zero, so a query scans nothing and gives all flags
    // clear, whatever the rectangle, and before any wall has been written.
    task automatic test_reset_state();
        send_item(make_item(MODE_QUERY, 0, 24'sh000100, 24'sh000100, 23'h000400, 23'h000400));
        send_item(make_item(MODE_QUERY, 63, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX));
    endtask

    // One wall spanning 1.0 to 5.0 on both axes, met by rectangles that set each
    // flag in turn, that touch its edges without overlapping, that have no width,
    // that match it exactly and that cover it.
    task automatic test_edge_flags();
        send_item(make_item(MODE_WRITE, 0, 24'sh000100, 24'sh000100, 23'h000400, 23'h000400));
        set_walls_in_use(1);
        send_item(make_item(MODE_QUERY, 0, 24'sh000200, 24'sh000200, 23'h000100, 23'h000100));
        send_item(make_item(MODE_QUERY, 0, 24'sh000000, 24'sh000200, 23'h000200, 23'h000100));
        send_item(make_item(MODE_QUERY, 0, 24'sh000200, 24'sh000400, 23'h000100, 23'h000200));
        send_item(make_item(MODE_QUERY, 0, 24'sh000500, 24'sh000200, 23'h000100, 23'h000100));
        send_item(make_item(MODE_QUERY, 0, 24'sh000200, 24'sh000000, 23'h000100, 23'h000100));
        send_item(make_item(MODE_QUERY, 0, 24'sh000200, 24'sh000200, 23'h000000, 23'h000100));
        send_item(make_item(MODE_QUERY, 0, 24'sh000100, 24'sh000100, 23'h000400, 23'h000400));
        send_item(make_item(MODE_QUERY, 0, 24'sh000000, 24'sh000000, 23'h000800, 23'h000800));
        send_item(make_item(MODE_QUERY, 0, 24'sh0004FF, 24'sh000200, 23'h000001, 23'h000100));
    endtask

    // Walls at the very ends of the coordinate range with the largest sizes; the
    // summed edges of the wall at the upper end need the extra bit.
    task automatic test_extreme_coords();
        send_item(make_item(MODE_WRITE, 0, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX));
        send_item(make_item(MODE_QUERY, 0, COORD_MAX, COORD_MAX, 23'h000001, 23'h000001));
        send_item(make_item(MODE_QUERY, 0, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX));
        send_item(make_item(MODE_QUERY, 0, -24'sd2, -24'sd2, 23'h000001, 23'h000001));
        send_item(make_item(MODE_WRITE, 1, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX));
        set_walls_in_use(2);
        send_item(make_item(MODE_QUERY, 0, COORD_MAX - 24'sd1, COORD_MAX - 24'sd1,
                            23'h000002, 23'h000002));
    endtask

    // Every slot is written before a count that scans it is set.
    task automatic test_table_fill();
        in_item_t it;
        set_idling(0);
        for (int i = 0; i < MAX_WALLS; i++) begin
            it      = random_rect();
            it.mode = MODE_WRITE;
            it.slot = SLOT_W'(i);
            send_item(it);
        end
    endtask

    // Mixed writes and queries under each idling mix, with the count at its
    // extremes, saturated above the table depth, and at random values between.
    task automatic test_random_traffic();
        int count;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: count = MAX_WALLS;
                1: count = (1 << CFG_W) - 1;
                2: count = 1;
                3: count = 0;
                4: count = $urandom_range(2, MAX_WALLS - 1);
                5: count = MAX_WALLS;
                6: count = $urandom_range(MAX_WALLS + 1, (1 << CFG_W) - 1);
                default: count = $urandom_range(0, MAX_WALLS);
            endcase
            set_walls_in_use(count);
            set_idling(phase);
            for (int n = 0; n < 60; n++) begin
                // Now and then the sender waits for the block to empty completely.
                if ($urandom_range(0, 39) == 0) hold_until_drained();
                send_item(random_rect());
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        scan_count     = '0;
        error_count    = 0;
        writes_sent    = 0;
        queries_sent   = 0;
        results_checked = 0;
        collided_seen  = 0;
        right_seen     = 0;
        left_seen      = 0;
        top_seen       = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_edge_flags();
        test_extreme_coords();
        test_table_fill();
        test_random_traffic();
        quiesce();

        $display("Covered %0d wall writes and %0d queries at counts from zero to a saturated",
                 writes_sent, queries_sent);
        $display("table, four idling mixes; %0d results checked, %0d collided, %0d %0d %0d r/l/t",
                 results_checked, collided_seen, right_seen, left_seen, top_seen);
        if (error_count == 0) begin
            $display("rect_wall_collision_sides test passed");
        end else begin
            $display("rect_wall_collision_sides test failed");
        end
        $finish;
    end

    // The slowest correct run is well under a tenth of this.
    initial begin
        #1600000;
        $display("rect_wall_collision_sides test failed");
        $finish;
    end

endmodule
